### hw/rtl/cie_pkg.sv
// shared types and opcode constants for the custom isa execute unit
package cie_pkg;

    localparam int WORD_BITS = 32;
    localparam int BYTE_BITS = 8;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 24;

    localparam logic [WORD_BITS-1:0] STACK_STEP = 32'd4;
    localparam logic [BYTE_BITS-1:0] OP_MOV  = 8'h00;
    localparam logic [BYTE_BITS-1:0] OP_LD   = 8'h01;
    localparam logic [BYTE_BITS-1:0] OP_ST   = 8'h02;
    localparam logic [BYTE_BITS-1:0] OP_LIH  = 8'h03;
    localparam logic [BYTE_BITS-1:0] OP_LIL  = 8'h04;
    localparam logic [BYTE_BITS-1:0] OP_SWP  = 8'h05;
    localparam logic [BYTE_BITS-1:0] OP_ADD  = 8'h10;
    localparam logic [BYTE_BITS-1:0] OP_SUB  = 8'h11;
    localparam logic [BYTE_BITS-1:0] OP_MUL  = 8'h12;
    localparam logic [BYTE_BITS-1:0] OP_DIV  = 8'h13;
    localparam logic [BYTE_BITS-1:0] OP_MOD  = 8'h14;
    localparam logic [BYTE_BITS-1:0] OP_ADDI = 8'h15;
    localparam logic [BYTE_BITS-1:0] OP_SUBI = 8'h16;
    localparam logic [BYTE_BITS-1:0] OP_MULI = 8'h17;
    localparam logic [BYTE_BITS-1:0] OP_DIVI = 8'h18;
    localparam logic [BYTE_BITS-1:0] OP_MODI = 8'h19;
    localparam logic [BYTE_BITS-1:0] OP_BEQ  = 8'h30;
    localparam logic [BYTE_BITS-1:0] OP_BNE  = 8'h31;
    localparam logic [BYTE_BITS-1:0] OP_BLT  = 8'h32;
    localparam logic [BYTE_BITS-1:0] OP_BGT  = 8'h33;
    localparam logic [BYTE_BITS-1:0] OP_BLE  = 8'h34;
    localparam logic [BYTE_BITS-1:0] OP_BGE  = 8'h35;
    localparam logic [BYTE_BITS-1:0] OP_AND  = 8'h50;
    localparam logic [BYTE_BITS-1:0] OP_OR   = 8'h51;
    localparam logic [BYTE_BITS-1:0] OP_XOR  = 8'h52;
    localparam logic [BYTE_BITS-1:0] OP_SHL  = 8'h53;
    localparam logic [BYTE_BITS-1:0] OP_SHR  = 8'h54;
    localparam logic [BYTE_BITS-1:0] OP_SHLI = 8'h55;
    localparam logic [BYTE_BITS-1:0] OP_SHRI = 8'h56;
    localparam logic [BYTE_BITS-1:0] OP_NOT  = 8'h57;
    localparam logic [BYTE_BITS-1:0] OP_OUT  = 8'h80;
    localparam logic [BYTE_BITS-1:0] OP_IN   = 8'h81;
    localparam logic [BYTE_BITS-1:0] OP_OUTI = 8'h82;
    localparam logic [BYTE_BITS-1:0] OP_INI  = 8'h83;
    localparam logic [BYTE_BITS-1:0] OP_PUSH = 8'h90;
    localparam logic [BYTE_BITS-1:0] OP_POP  = 8'h91;
    localparam logic [BYTE_BITS-1:0] OP_CLR  = 8'hC0;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_OP  = 2'd1;
    localparam logic [1:0] ST_DIV0    = 2'd2;
    localparam logic [1:0] ST_BAD_CLR = 2'd3;

    // register file write / valid-clear request
    typedef struct packed {
        logic                  wr;
        logic                  clr;
        logic [BYTE_BITS-1:0]  idx;
        logic [WORD_BITS-1:0]  data;
    } rf_req_t;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_RDB  = 12'b000000000010,
        S_RDC  = 12'b000000000100,
        S_RWT  = 12'b000000001000,
        S_EXEC = 12'b000000010000,
        S_DIV  = 12'b000000100000,
        S_MEM  = 12'b000001000000,
        S_MRD  = 12'b000010000000,
        S_SWP  = 12'b000100000000,
        S_CLR  = 12'b001000000000,
        S_DONE = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } state_t;

endpackage

### hw/rtl/cie_regfile.sv
// register file memory with per-entry valid bits, invalid entries read as zero
module cie_regfile #(
    parameter int NUM_REGS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [$clog2(NUM_REGS)-1:0]     rd_idx,
    output logic [cie_pkg::WORD_BITS-1:0]   rd_data,
    input  cie_pkg::rf_req_t                req
);
    localparam int RIDX_W = $clog2(NUM_REGS);

    logic [cie_pkg::WORD_BITS-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]           valid_reg;
    logic [cie_pkg::WORD_BITS-1:0] q_reg;
    logic                          qv_reg;
    logic [RIDX_W-1:0]             w_idx;

    assign w_idx = req.idx[RIDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[w_idx] <= req.data;
        end
        q_reg <= mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end else begin
            qv_reg <= valid_reg[rd_idx];
            if (req.wr) begin
                valid_reg[w_idx] <= 1'b1;
            end else if (req.clr) begin
                valid_reg[w_idx] <= 1'b0;
            end
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

### hw/rtl/cie_dmem.sv
// word data memory with a zeroing sweep after reset
module cie_dmem #(
    parameter int MEM_WORDS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [$clog2(MEM_WORDS)-1:0]    addr,
    input  logic [cie_pkg::WORD_BITS-1:0]   wr_data,
    output logic [cie_pkg::WORD_BITS-1:0]   rd_data,
    output logic                            busy
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [cie_pkg::WORD_BITS-1:0] mem [MEM_WORDS];
    logic [AW-1:0]                 sweep_reg;
    logic                          busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
            busy_reg  <= 1'b1;
        end else if (busy_reg) begin
            sweep_reg <= sweep_reg + 1'b1;
            if (sweep_reg == AW'(MEM_WORDS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[sweep_reg] <= '0;
        end else if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

    assign busy = busy_reg;

endmodule

### hw/rtl/cie_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module cie_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [cie_pkg::WORD_BITS-1:0]   dividend,
    input  logic [cie_pkg::WORD_BITS-1:0]   divisor,
    output logic                            done,
    output logic [cie_pkg::WORD_BITS-1:0]   quot,
    output logic [cie_pkg::WORD_BITS-1:0]   rem
);
    localparam int W = cie_pkg::WORD_BITS;
    localparam int CW = $clog2(W);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/custom_isa_execute_unit.sv
// execute unit top: instruction sequencer around register file and data memory
//
//  channel  dir  beat contents
//  s_       in   one decoded instruction (opcode, three operands, port read byte)
//  m_       out  one result per instruction (status, halt, branch, port activity)
//
// from accept to the next s_tready: three reads on the one register file port,
// execute, result. divide and modulo wait in S_DIV for the divider; store and
// push add S_MEM, load and pop S_MEM and S_MRD, plus S_DIV for address reduction
// when MEM_WORDS is not a power of two. register clear steps S_CLR per register.
// after reset s_tready stays low while memory is zeroed; a stalled result holds in
// the output register while the next beat is taken in.
module custom_isa_execute_unit #(
    parameter int NUM_REGS  = 256,
    parameter int MEM_WORDS = 1024,
    parameter int PC_INDEX  = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode, op_a, op_b, op_c, port_read_data
    input  logic [cie_pkg::S_DATA_BITS-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], halted, branch_taken, port_write_valid, port_number[7:0],
    // port_write_data[7:0], port_read_valid, zero fill
    output logic [cie_pkg::M_DATA_BITS-1:0]     m_tdata
);
    localparam int W      = cie_pkg::WORD_BITS;
    localparam int B      = cie_pkg::BYTE_BITS;
    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int AW     = $clog2(MEM_WORDS);
    localparam int PC_REG = PC_INDEX % NUM_REGS;
    localparam bit MEM_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    // reciprocal for word address modulo MEM_WORDS, exact for 30-bit addresses
    localparam int MSH = 30 + $clog2(MEM_WORDS);
    localparam logic [30:0] MREC =
        31'(((64'd1 << MSH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

    // operand byte to register index, modulo NUM_REGS
    logic [RIDX_W-1:0] reg_mod [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_mod
        assign reg_mod[gi] = RIDX_W'(gi % NUM_REGS);
    end

    cie_pkg::state_t state_reg, state_next;
    logic [B-1:0]  mode_reg, a_reg, b_reg, c_reg, prd_reg;
    logic [B-1:0]  mode_next, a_next, b_next, c_next, prd_next;
    logic [W-1:0]  ra_reg, rb_reg, rc_reg, ra_next, rb_next, rc_next;
    logic [1:0]    status_reg, status_next;
    logic          halted_reg, halted_next, taken_reg, taken_next;
    logic          pwv_reg, pwv_next, prv_reg, prv_next;
    logic [B-1:0]  pnum_reg, pnum_next, pwd_reg, pwd_next;
    logic [RIDX_W-1:0] widx_reg, widx_next;
    logic          mflag_reg, mflag_next;
    logic [AW-1:0] maddr_reg, maddr_next;
    logic [B-1:0]  clr_reg, clr_next;
    logic          mv_reg, mv_next;
    logic [cie_pkg::M_DATA_BITS-1:0] md_reg, md_next;
    logic [W-1:0]  mq_reg, mq_next;

    logic [RIDX_W-1:0] ia, ib, ic, rd_idx;
    logic [W-1:0]  rf_rdata, dm_rdata, imm, mem_word;
    logic [60:0]   mprod;
    logic [W-1:0]  mrem;
    cie_pkg::rf_req_t rf_req;
    logic          dm_we, dm_busy;
    logic [W-1:0]  dm_wdata;
    logic          div_start, div_done;
    logic [W-1:0]  div_n, div_d, div_q, div_r;
    logic          cond;
    logic          in_acc;

    assign ia  = reg_mod[a_reg];
    assign ib  = reg_mod[b_reg];
    assign ic  = reg_mod[c_reg];
    assign imm = {16'b0, b_reg, c_reg};

    assign s_tready = (state_reg == cie_pkg::S_IDLE) && !dm_busy;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb begin
        case (state_reg)
            cie_pkg::S_IDLE: rd_idx = reg_mod[s_tdata[15:8]];
            cie_pkg::S_RDB:  rd_idx = ib;
            default:         rd_idx = ic;
        endcase
    end

    cie_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
        .aclk(aclk), .aresetn(aresetn), .rd_idx(rd_idx), .rd_data(rf_rdata), .req(rf_req)
    );

    cie_dmem #(.MEM_WORDS(MEM_WORDS)) u_dm (
        .aclk(aclk), .aresetn(aresetn), .wr_en(dm_we), .addr(maddr_reg),
        .wr_data(dm_wdata), .rd_data(dm_rdata), .busy(dm_busy)
    );

    cie_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_n),
        .divisor(div_d), .done(div_done), .quot(div_q), .rem(div_r)
    );

    always_comb begin
        case (mode_reg)
            cie_pkg::OP_BEQ: cond = ra_reg == rb_reg;
            cie_pkg::OP_BNE: cond = ra_reg != rb_reg;
            cie_pkg::OP_BLT: cond = ra_reg <  rb_reg;
            cie_pkg::OP_BGT: cond = ra_reg >  rb_reg;
            cie_pkg::OP_BLE: cond = ra_reg <= rb_reg;
            default:         cond = ra_reg >= rb_reg;
        endcase
    end

    // word address for memory opcodes, before reduction modulo MEM_WORDS
    always_comb begin
        case (mode_reg)
            cie_pkg::OP_LD:  mem_word = {2'b0, rb_reg[W-1:2]};
            cie_pkg::OP_POP: mem_word = {2'b0, rc_next[W-1:2]};
            default:         mem_word = {2'b0, rc_reg[W-1:2]};
        endcase
    end

    // quotient by reciprocal in S_EXEC, remainder from the registered quotient in S_DIV
    assign mprod = mem_word[29:0] * MREC;
    assign mrem  = mem_word - W'(mq_reg * W'(MEM_WORDS));

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        prd_next    = prd_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rc_next     = rc_reg;
        status_next = status_reg;
        halted_next = halted_reg;
        taken_next  = taken_reg;
        pwv_next    = pwv_reg;
        prv_next    = prv_reg;
        pnum_next   = pnum_reg;
        pwd_next    = pwd_reg;
        widx_next   = widx_reg;
        mflag_next  = mflag_reg;
        maddr_next  = maddr_reg;
        clr_next    = clr_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        mq_next     = mq_reg;
        rf_req      = '0;
        dm_we       = 1'b0;
        dm_wdata    = rb_reg;
        div_start   = 1'b0;
        div_n       = ra_reg;
        div_d       = rb_reg;

        case (state_reg)
            cie_pkg::S_IDLE: begin
                if (in_acc) begin
                    mode_next   = s_tdata[7:0];
                    a_next      = s_tdata[15:8];
                    b_next      = s_tdata[23:16];
                    c_next      = s_tdata[31:24];
                    prd_next    = s_tdata[39:32];
                    status_next = cie_pkg::ST_OK;
                    halted_next = 1'b0;
                    taken_next  = 1'b0;
                    pwv_next    = 1'b0;
                    prv_next    = 1'b0;
                    pnum_next   = '0;
                    pwd_next    = '0;
                    state_next  = cie_pkg::S_RDB;
                end
            end
            cie_pkg::S_RDB: begin
                ra_next    = rf_rdata;
                state_next = cie_pkg::S_RDC;
            end
            cie_pkg::S_RDC: begin
                rb_next    = rf_rdata;
                state_next = cie_pkg::S_RWT;
            end
            cie_pkg::S_RWT: begin
                rc_next    = rf_rdata;
                state_next = cie_pkg::S_EXEC;
            end
            cie_pkg::S_EXEC: begin
                state_next = cie_pkg::S_DONE;
                rf_req.idx = B'(ic);
                case (mode_reg)
                    cie_pkg::OP_MOV: begin
                        rf_req.wr = 1'b1; rf_req.data = rb_reg;
                    end
                    cie_pkg::OP_LIH: begin
                        rf_req.wr = 1'b1; rf_req.idx = B'(ia);
                        rf_req.data = {imm[15:0], ra_reg[15:0]};
                    end
                    cie_pkg::OP_LIL: begin
                        rf_req.wr = 1'b1; rf_req.idx = B'(ia);
                        rf_req.data = {ra_reg[15:0], imm[15:0]};
                    end
                    cie_pkg::OP_SWP: begin
                        // xor swap of a register with itself clears it
                        rf_req.wr = 1'b1; rf_req.idx = B'(ib);
                        rf_req.data = (ib == ic) ? '0 : rc_reg;
                        if (ib != ic) begin
                            state_next = cie_pkg::S_SWP;
                        end
                    end
                    cie_pkg::OP_ADD: begin
                        rf_req.wr = 1'b1; rf_req.data = ra_reg + rb_reg;
                    end
                    cie_pkg::OP_SUB: begin
                        rf_req.wr = 1'b1; rf_req.data = ra_reg - rb_reg;
                    end
                    cie_pkg::OP_MUL: begin
                        rf_req.wr = 1'b1; rf_req.data = W'(ra_reg * rb_reg);
                    end
                    cie_pkg::OP_ADDI: begin
                        rf_req.wr = 1'b1; rf_req.idx = B'(ia); rf_req.data = ra_reg + imm;
                    end
                    cie_pkg::OP_SUBI: begin
                        rf_req.wr = 1'b1; rf_req.idx = B'(ia); rf_req.data = ra_reg - imm;
                    end
                    cie_pkg::OP_MULI: begin
                        rf_req.wr = 1'b1; rf_req.idx = B'(ia);
                        rf_req.data = W'(ra_reg * imm);
                    end
                    cie_pkg::OP_DIV, cie_pkg::OP_MOD, cie_pkg::OP_DIVI,
                    cie_pkg::OP_MODI: begin
                        if (mode_reg == cie_pkg::OP_DIV || mode_reg == cie_pkg::OP_MOD) begin
                            div_d     = rb_reg;
                            widx_next = ic;
                        end else begin
                            div_d     = imm;
                            widx_next = ia;
                        end
                        if (div_d == '0) begin
                            status_next = cie_pkg::ST_DIV0;
                            halted_next = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            mflag_next = 1'b0;
                            state_next = cie_pkg::S_DIV;
                        end
                    end
                    cie_pkg::OP_BEQ, cie_pkg::OP_BNE, cie_pkg::OP_BLT, cie_pkg::OP_BGT,
                    cie_pkg::OP_BLE, cie_pkg::OP_BGE: begin
                        if (cond) begin
                            rf_req.wr   = 1'b1;
                            rf_req.idx  = B'(PC_REG);
                            rf_req.data = rc_reg - cie_pkg::STACK_STEP;
                            taken_next  = 1'b1;
                        end
                    end
                    cie_pkg::OP_AND: begin
                        rf_req.wr = 1'b1; rf_req.data = ra_reg & rb_reg;
                    end
                    cie_pkg::OP_OR: begin
                        rf_req.wr = 1'b1; rf_req.data = ra_reg | rb_reg;
                    end
                    cie_pkg::OP_XOR: begin
                        rf_req.wr = 1'b1; rf_req.data = ra_reg ^ rb_reg;
                    end
                    cie_pkg::OP_SHL: begin
                        rf_req.wr = 1'b1;
                        rf_req.data = (rb_reg >= W) ? '0 : ra_reg << rb_reg[4:0];
                    end
                    cie_pkg::OP_SHR: begin
                        rf_req.wr = 1'b1;
                        rf_req.data = (rb_reg >= W) ? '0 : ra_reg >> rb_reg[4:0];
                    end
                    cie_pkg::OP_SHLI: begin
                        rf_req.wr = 1'b1;
                        rf_req.data = (b_reg >= B'(W)) ? '0 : ra_reg << b_reg[4:0];
                    end
                    cie_pkg::OP_SHRI: begin
                        rf_req.wr = 1'b1;
                        rf_req.data = (b_reg >= B'(W)) ? '0 : ra_reg >> b_reg[4:0];
                    end
                    cie_pkg::OP_NOT: begin
                        rf_req.wr = 1'b1; rf_req.data = ~rb_reg;
                    end
                    cie_pkg::OP_OUT: begin
                        pwv_next = 1'b1; pnum_next = rc_reg[7:0]; pwd_next = rb_reg[7:0];
                    end
                    cie_pkg::OP_OUTI: begin
                        pwv_next = 1'b1; pnum_next = c_reg; pwd_next = rb_reg[7:0];
                    end
                    cie_pkg::OP_IN: begin
                        prv_next = 1'b1; pnum_next = rb_reg[7:0];
                        rf_req.wr = 1'b1; rf_req.data = {24'b0, prd_reg};
                    end
                    cie_pkg::OP_INI: begin
                        prv_next = 1'b1; pnum_next = b_reg;
                        rf_req.wr = 1'b1; rf_req.data = {24'b0, prd_reg};
                    end
                    cie_pkg::OP_LD, cie_pkg::OP_ST, cie_pkg::OP_PUSH, cie_pkg::OP_POP: begin
                        if (mode_reg == cie_pkg::OP_POP) begin
                            rc_next     = rc_reg - cie_pkg::STACK_STEP;
                            rf_req.wr   = 1'b1;
                            rf_req.data = rc_next;
                        end
                        if (MEM_POW2) begin
                            maddr_next = mem_word[AW-1:0];
                            state_next = cie_pkg::S_MEM;
                        end else begin
                            mq_next    = W'(mprod >> MSH);
                            mflag_next = 1'b1;
                            state_next = cie_pkg::S_DIV;
                        end
                    end
                    cie_pkg::OP_CLR: begin
                        if (b_reg > c_reg) begin
                            status_next = cie_pkg::ST_BAD_CLR;
                            halted_next = 1'b1;
                        end else begin
                            clr_next   = b_reg;
                            state_next = cie_pkg::S_CLR;
                        end
                    end
                    default: begin
                        status_next = cie_pkg::ST_BAD_OP;
                    end
                endcase
            end
            cie_pkg::S_DIV: begin
                if (mflag_reg) begin
                    maddr_next = mrem[AW-1:0];
                    state_next = cie_pkg::S_MEM;
                end else if (div_done) begin
                    rf_req.wr   = 1'b1;
                    rf_req.idx  = B'(widx_reg);
                    rf_req.data = (mode_reg == cie_pkg::OP_DIV ||
                                   mode_reg == cie_pkg::OP_DIVI) ? div_q : div_r;
                    state_next  = cie_pkg::S_DONE;
                end
            end
            cie_pkg::S_MEM: begin
                if (mode_reg == cie_pkg::OP_LD || mode_reg == cie_pkg::OP_POP) begin
                    state_next = cie_pkg::S_MRD;
                end else begin
                    dm_we = 1'b1;
                    if (mode_reg == cie_pkg::OP_PUSH) begin
                        rf_req.wr   = 1'b1;
                        rf_req.idx  = B'(ic);
                        rf_req.data = rc_reg + cie_pkg::STACK_STEP;
                    end
                    state_next = cie_pkg::S_DONE;
                end
            end
            cie_pkg::S_MRD: begin
                rf_req.wr   = 1'b1;
                rf_req.idx  = (mode_reg == cie_pkg::OP_LD) ? B'(ic) : B'(ib);
                rf_req.data = dm_rdata;
                state_next  = cie_pkg::S_DONE;
            end
            cie_pkg::S_SWP: begin
                rf_req.wr   = 1'b1;
                rf_req.idx  = B'(ic);
                rf_req.data = rb_reg;
                state_next  = cie_pkg::S_DONE;
            end
            cie_pkg::S_CLR: begin
                rf_req.clr = 1'b1;
                rf_req.idx = B'(reg_mod[clr_reg]);
                clr_next   = clr_reg + 1'b1;
                // stop on the last index so a range ending at 255 does not wrap
                if (clr_reg == c_reg) begin
                    state_next = cie_pkg::S_DONE;
                end
            end
            cie_pkg::S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {2'b0, prv_reg, pwd_reg, pnum_reg, pwv_reg,
                                  taken_reg, halted_reg, status_reg};
                    state_next = cie_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cie_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cie_pkg::S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        prd_reg    <= prd_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rc_reg     <= rc_next;
        status_reg <= status_next;
        halted_reg <= halted_next;
        taken_reg  <= taken_next;
        pwv_reg    <= pwv_next;
        prv_reg    <= prv_next;
        pnum_reg   <= pnum_next;
        pwd_reg    <= pwd_next;
        widx_reg   <= widx_next;
        mflag_reg  <= mflag_next;
        maddr_reg  <= maddr_next;
        clr_reg    <= clr_next;
        md_reg     <= md_next;
        mq_reg     <= mq_next;
    end

endmodule

### hw/rtl/cie_checker.sv
// port-level checks for the execute unit, bound to the top level
module cie_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cie_pkg::M_DATA_BITS-1:0]  m_tdata
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // halt is reported exactly for divide by zero and bad clear range
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] == cie_pkg::ST_DIV0 ||
                                     m_tdata[1:0] == cie_pkg::ST_BAD_CLR)))
        else $error("halt flag disagrees with status");

    // port in and port out never in the same result
    a_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[21]))
        else $error("port read and write in one result");

    // failing instructions report no branch or port activity
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != cie_pkg::ST_OK |->
            !m_tdata[3] && !m_tdata[4] && !m_tdata[21] && m_tdata[20:5] == '0)
        else $error("side effects reported on a failing instruction");
endmodule

bind custom_isa_execute_unit cie_checker u_cie_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
);

### test/tb_top.sv
// testbench for the execute unit: drives instructions, predicts each result beat
module tb_top;

    localparam int NREGS = 256;
    localparam int NWORDS = 1024;
    localparam int PC_REG = 255;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] status;
        logic       halted;
        logic       taken;
        logic       pw_valid;
        logic [7:0] pnum;
        logic [7:0] pw_data;
        logic       pr_valid;
    } outcome_t;

    class exec_scoreboard;
        logic [31:0] regs [NREGS];
        logic [31:0] dmem [NWORDS];
        outcome_t pending[$];
        int errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            errors = 0;
        endfunction

        function automatic int word_of(logic [31:0] addr);
            return int'((addr >> 2) % NWORDS);
        endfunction

        function automatic logic [31:0] shl(logic [31:0] v, logic [31:0] n);
            return (n >= 32) ? 32'd0 : v << n;
        endfunction

        function automatic logic [31:0] shr(logic [31:0] v, logic [31:0] n);
            return (n >= 32) ? 32'd0 : v >> n;
        endfunction

        // execute one instruction on the shadow state, queue its outcome
        function void note_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                                 logic [7:0] c, logic [7:0] prd);
            logic [31:0] ra, rb, rc, imm;
            logic cond;
            outcome_t r;
            r = '0;
            ra = regs[a]; rb = regs[b]; rc = regs[c];
            imm = {16'd0, b, c};
            cond = 1'b0;
            case (op)
                cie_pkg::OP_MOV: regs[c] = rb;
                cie_pkg::OP_LD: regs[c] = dmem[word_of(rb)];
                cie_pkg::OP_ST: dmem[word_of(rc)] = rb;
                cie_pkg::OP_LIH: regs[a] = {imm[15:0], ra[15:0]};
                cie_pkg::OP_LIL: regs[a] = {ra[15:0], imm[15:0]};
                cie_pkg::OP_SWP: begin
                    regs[b] = regs[b] ^ regs[c];
                    regs[c] = regs[c] ^ regs[b];
                    regs[b] = regs[b] ^ regs[c];
                end
                cie_pkg::OP_ADD: regs[c] = ra + rb;
                cie_pkg::OP_SUB: regs[c] = ra - rb;
                cie_pkg::OP_MUL: regs[c] = ra * rb;
                cie_pkg::OP_DIV, cie_pkg::OP_MOD: begin
                    if (rb == 0) begin
                        r.status = cie_pkg::ST_DIV0; r.halted = 1'b1;
                    end else begin
                        regs[c] = (op == cie_pkg::OP_DIV) ? ra / rb : ra % rb;
                    end
                end
                cie_pkg::OP_ADDI: regs[a] = ra + imm;
                cie_pkg::OP_SUBI: regs[a] = ra - imm;
                cie_pkg::OP_MULI: regs[a] = ra * imm;
                cie_pkg::OP_DIVI, cie_pkg::OP_MODI: begin
                    if (imm == 0) begin
                        r.status = cie_pkg::ST_DIV0; r.halted = 1'b1;
                    end else begin
                        regs[a] = (op == cie_pkg::OP_DIVI) ? ra / imm : ra % imm;
                    end
                end
                cie_pkg::OP_BEQ, cie_pkg::OP_BNE, cie_pkg::OP_BLT, cie_pkg::OP_BGT,
                cie_pkg::OP_BLE, cie_pkg::OP_BGE: begin
                    case (op)
                        cie_pkg::OP_BEQ: cond = ra == rb;
                        cie_pkg::OP_BNE: cond = ra != rb;
                        cie_pkg::OP_BLT: cond = ra < rb;
                        cie_pkg::OP_BGT: cond = ra > rb;
                        cie_pkg::OP_BLE: cond = ra <= rb;
                        default: cond = ra >= rb;
                    endcase
                    if (cond) begin
                        regs[PC_REG] = rc - cie_pkg::STACK_STEP; r.taken = 1'b1;
                    end
                end
                cie_pkg::OP_AND: regs[c] = ra & rb;
                cie_pkg::OP_OR: regs[c] = ra | rb;
                cie_pkg::OP_XOR: regs[c] = ra ^ rb;
                cie_pkg::OP_SHL: regs[c] = shl(ra, rb);
                cie_pkg::OP_SHR: regs[c] = shr(ra, rb);
                cie_pkg::OP_SHLI: regs[c] = shl(ra, {24'd0, b});
                cie_pkg::OP_SHRI: regs[c] = shr(ra, {24'd0, b});
                cie_pkg::OP_NOT: regs[c] = ~rb;
                cie_pkg::OP_OUT: begin
                    r.pw_valid = 1'b1; r.pnum = rc[7:0]; r.pw_data = rb[7:0];
                end
                cie_pkg::OP_IN: begin
                    r.pr_valid = 1'b1; r.pnum = rb[7:0]; regs[c] = {24'd0, prd};
                end
                cie_pkg::OP_OUTI: begin
                    r.pw_valid = 1'b1; r.pnum = c; r.pw_data = rb[7:0];
                end
                cie_pkg::OP_INI: begin
                    r.pr_valid = 1'b1; r.pnum = b; regs[c] = {24'd0, prd};
                end
                cie_pkg::OP_PUSH: begin
                    dmem[word_of(rc)] = rb;
                    regs[c] = regs[c] + cie_pkg::STACK_STEP;
                end
                cie_pkg::OP_POP: begin
                    regs[c] = rc - cie_pkg::STACK_STEP;
                    regs[b] = dmem[word_of(regs[c])];
                end
                cie_pkg::OP_CLR: begin
                    if (b <= c) begin
                        for (int i = b; i <= c; i++) regs[i] = '0;
                    end else begin
                        r.status = cie_pkg::ST_BAD_CLR; r.halted = 1'b1;
                    end
                end
                default: r.status = cie_pkg::ST_BAD_OP;
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("error: %s got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [23:0] beat);
            outcome_t want, got;
            got.status = beat[1:0];
            got.halted = beat[2];
            got.taken = beat[3];
            got.pw_valid = beat[4];
            got.pnum = beat[12:5];
            got.pw_data = beat[20:13];
            got.pr_valid = beat[21];
            if (pending.size() == 0) begin
                report("unexpected result", 32'(beat), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.halted != want.halted)
                report("halted", 32'(got.halted), 32'(want.halted));
            if (got.taken != want.taken)
                report("branch_taken", 32'(got.taken), 32'(want.taken));
            if (got.pw_valid != want.pw_valid)
                report("port_write_valid", 32'(got.pw_valid), 32'(want.pw_valid));
            if (got.pnum != want.pnum)
                report("port_number", 32'(got.pnum), 32'(want.pnum));
            if (got.pw_data != want.pw_data)
                report("port_write_data", 32'(got.pw_data), 32'(want.pw_data));
            if (got.pr_valid != want.pr_valid)
                report("port_read_valid", 32'(got.pr_valid), 32'(want.pr_valid));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [cie_pkg::S_DATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [cie_pkg::M_DATA_BITS-1:0] m_tdata;

    exec_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    logic timed_out = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    custom_isa_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // result side: random stall, check on accepted beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCH_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("custom_isa_execute_unit: mismatch");
            $finish;
        end
    end

    // s_tvalid drops only for idle gaps, so back-to-back beats keep it high
    task automatic send_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                              logic [7:0] c, logic [7:0] prd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {prd, c, b, a, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_instr(op, a, b, c, prd);
    endtask

    localparam logic [7:0] VALID_OPS [39] = '{
        cie_pkg::OP_MOV, cie_pkg::OP_LD, cie_pkg::OP_ST, cie_pkg::OP_LIH,
        cie_pkg::OP_LIL, cie_pkg::OP_SWP, cie_pkg::OP_ADD, cie_pkg::OP_SUB,
        cie_pkg::OP_MUL, cie_pkg::OP_DIV, cie_pkg::OP_MOD, cie_pkg::OP_ADDI,
        cie_pkg::OP_SUBI, cie_pkg::OP_MULI, cie_pkg::OP_DIVI, cie_pkg::OP_MODI,
        cie_pkg::OP_BEQ, cie_pkg::OP_BNE, cie_pkg::OP_BLT, cie_pkg::OP_BGT,
        cie_pkg::OP_BLE, cie_pkg::OP_BGE, cie_pkg::OP_AND, cie_pkg::OP_OR,
        cie_pkg::OP_XOR, cie_pkg::OP_SHL, cie_pkg::OP_SHR, cie_pkg::OP_SHLI,
        cie_pkg::OP_SHRI, cie_pkg::OP_NOT, cie_pkg::OP_OUT, cie_pkg::OP_IN,
        cie_pkg::OP_OUTI, cie_pkg::OP_INI, cie_pkg::OP_PUSH, cie_pkg::OP_POP,
        cie_pkg::OP_CLR, cie_pkg::OP_MOV, cie_pkg::OP_ADD};

    // operands mostly from a few registers so values chain; clears kept short
    task automatic send_random();
        logic [7:0] op, a, b, c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) op = 8'($urandom_range(255));
        else op = VALID_OPS[$urandom_range(38)];
        a = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
        if (op == cie_pkg::OP_CLR && $urandom_range(9) != 0) c = 8'(b + $urandom_range(4));
        send_instr(op, a, b, c, 8'($urandom_range(255)));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes and special cases
        send_instr(cie_pkg::OP_LIL, 8'd1, 8'hFF, 8'hFF, 8'h00);
        send_instr(cie_pkg::OP_LIH, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        send_instr(cie_pkg::OP_LIL, 8'd2, 8'h00, 8'd40, 8'h00);
        send_instr(cie_pkg::OP_SHL, 8'd1, 8'd2, 8'd3, 8'h00);
        send_instr(cie_pkg::OP_SHRI, 8'd1, 8'd32, 8'd4, 8'h00);
        send_instr(cie_pkg::OP_SHLI, 8'd1, 8'd31, 8'd4, 8'h00);
        send_instr(cie_pkg::OP_DIV, 8'd1, 8'd9, 8'd5, 8'h00);
        send_instr(cie_pkg::OP_MODI, 8'd1, 8'd0, 8'd0, 8'h00);
        send_instr(cie_pkg::OP_DIVI, 8'd1, 8'hFF, 8'hFF, 8'h00);
        send_instr(cie_pkg::OP_SWP, 8'd0, 8'd1, 8'd1, 8'h00);
        send_instr(cie_pkg::OP_IN, 8'd0, 8'd2, 8'd255, 8'hFF);
        send_instr(cie_pkg::OP_OUT, 8'd0, 8'd255, 8'd2, 8'h00);
        send_instr(cie_pkg::OP_INI, 8'd0, 8'hFF, 8'd6, 8'hA5);
        send_instr(cie_pkg::OP_OUTI, 8'd0, 8'd6, 8'hFF, 8'h00);
        send_instr(cie_pkg::OP_PUSH, 8'd0, 8'd6, 8'd7, 8'h00);
        send_instr(cie_pkg::OP_POP, 8'd0, 8'd8, 8'd7, 8'h00);
        send_instr(cie_pkg::OP_BGE, 8'd6, 8'd7, 8'd2, 8'h00);
        send_instr(cie_pkg::OP_CLR, 8'd0, 8'd250, 8'd255, 8'h00);
        send_instr(cie_pkg::OP_CLR, 8'd0, 8'd9, 8'd8, 8'h00);
        send_instr(cie_pkg::OP_CLR, 8'd0, 8'd255, 8'd255, 8'h00);
        send_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_instr(cie_pkg::OP_NOT, 8'd0, 8'd0, 8'd10, 8'h00);
        send_instr(cie_pkg::OP_ST, 8'd0, 8'd10, 8'd10, 8'h00);
        send_instr(cie_pkg::OP_LD, 8'd0, 8'd10, 8'd11, 8'h00);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 66; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 66; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            repeat (250) send_random();
        end
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) $display("custom_isa_execute_unit: match");
        else $display("custom_isa_execute_unit: mismatch");
        $finish;
    end
endmodule
